/* design/lph_pkg.sv */
// Shared package for the linear-probe hash table.
// Holds table geometry, the hash constant, command and status codes, and the item type.
package lph_pkg;

    localparam int SLOTS  = 1024;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SLOT_W = 10;
    localparam int PAY_W  = 32;

    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_ERASE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_MISS = 3'd1;
    localparam logic [2:0] ST_DUP  = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;

    typedef enum logic [2:0] {
        CMD_LOOKUP,
        CMD_INSERT,
        CMD_ERASE,
        CMD_READ,
        CMD_CLEAR,
        CMD_MISS,
        CMD_ZERO
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [63:0]      key;
        logic [IDX_W-1:0] slot;
        logic [PAY_W-1:0] payload;
    } item_t;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_RD,
        B_CMP,
        B_EZERO,
        B_ERD,
        B_ECMP,
        B_EHASH,
        B_EMIT
    } bstate_t;

endpackage

/* design/linear_probe_hash_table.sv */
// Linear-probe hash table top level: front, two-entry queue and back with the slot store.
// One item is worked on at a time in the back; the store's single read port sets the pace.
// After reset the back zeroes all SLOTS entries, one per cycle, with in_stall high.
// Depends on lph_pkg, lph_front, lph_queue and lph_back.
module linear_probe_hash_table import lph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        op,
    input  logic [63:0]       key,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic [PAY_W-1:0]  payload_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [SLOT_W-1:0] slot_out,
    output logic [63:0]       key_out,
    output logic [PAY_W-1:0]  payload_out
);

    logic  init_busy;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    item_t push_item;
    item_t pop_item;

    lph_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .key        (key),
        .slot_index (slot_index),
        .payload_in (payload_in),
        .init_busy  (init_busy),
        .q_full     (q_full),
        .push       (q_push),
        .push_item  (push_item)
    );

    lph_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    lph_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_out    (slot_out),
        .key_out     (key_out),
        .payload_out (payload_out)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("Item pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("Item popped from an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n) init_busy |-> (!q_pop && in_stall))
        else $error("Item handled during the store clearing pass.");

endmodule

/* design/lph_hash.sv */
// Home-slot hash unit: low 64 bits of key times the golden-ratio constant, top bits.
// Uses one 32x32 multiplier; depends on lph_pkg.
module lph_hash import lph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [63:0]      key,
    output logic             done,
    output logic [IDX_W-1:0] home
);

    logic [1:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [63:0]      key_reg;
    logic [31:0]      hi_reg;
    logic [31:0]      acc_reg;
    logic [IDX_W-1:0] home_reg;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic [31:0]      sum;

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:
            begin
                mul_a = key_reg[31:0];
                mul_b = HASH_MULT[31:0];
            end
            2'd1:
            begin
                mul_a = key_reg[63:32];
                mul_b = HASH_MULT[31:0];
            end
            default:
            begin
                mul_a = key_reg[31:0];
                mul_b = HASH_MULT[63:32];
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
        sum  = hi_reg + acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 2'd3);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
        end
        else if (busy_reg)
        begin
            unique case (cnt_reg)
                2'd0: hi_reg   <= prod[63:32];
                2'd1: acc_reg  <= prod[31:0];
                2'd2: acc_reg  <= acc_reg + prod[31:0];
                default: home_reg <= sum[31 -: IDX_W];
            endcase
        end
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

/* design/lph_queue.sv */
// Two-entry item queue between the front and back parts.
// Depends on lph_pkg for the item type.
module lph_queue import lph_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t pop_item,
    output logic  full,
    output logic  empty
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule

/* design/lph_front.sv */
// Front part: accepts items, classifies them and hashes lookup and insert keys to their home slot.
// Depends on lph_pkg and lph_hash.
module lph_front import lph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        op,
    input  logic [63:0]       key,
    input  logic [SLOT_W-1:0] slot_index,
    input  logic [PAY_W-1:0]  payload_in,
    input  logic              init_busy,
    input  logic              q_full,
    output logic              push,
    output item_t             push_item
);

    logic  stage_valid_reg;
    logic  wait_hash_reg;
    item_t stage_reg;
    item_t cls;
    logic  accept;
    logic  hash_start;
    logic  hash_done;
    logic [IDX_W-1:0] hash_home;
    logic  in_range;

    always_comb
    begin
        in_range    = (32'(slot_index) < SLOTS);
        cls.key     = key;
        cls.slot    = IDX_W'(slot_index);
        cls.payload = payload_in;
        unique case (op)
            OP_LOOKUP: cls.cmd = (key == '0) ? CMD_MISS : CMD_LOOKUP;
            OP_INSERT: cls.cmd = (key == '0) ? CMD_ZERO : CMD_INSERT;
            OP_ERASE:  cls.cmd = in_range ? CMD_ERASE : CMD_MISS;
            OP_READ:   cls.cmd = in_range ? CMD_READ : CMD_MISS;
            OP_CLEAR:  cls.cmd = CMD_CLEAR;
            default:   cls.cmd = CMD_MISS;
        endcase
    end

    assign in_stall   = stage_valid_reg || init_busy;
    assign accept     = in_valid && !in_stall;
    assign hash_start = accept && (cls.cmd == CMD_LOOKUP || cls.cmd == CMD_INSERT);
    assign push       = stage_valid_reg && !wait_hash_reg && !q_full;

    lph_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key),
        .done  (hash_done),
        .home  (hash_home)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            wait_hash_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
                wait_hash_reg   <= hash_start;
            end
            else
            begin
                if (push)
                begin
                    stage_valid_reg <= 1'b0;
                end
                if (hash_done)
                begin
                    wait_hash_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= cls;
        end
        else if (hash_done)
        begin
            stage_reg.slot <= hash_home;
        end
    end

    assign push_item = stage_reg;

endmodule

/* design/lph_back.sv */
// Back part: slot store, probing, insert, read, backward-shift erase, clear and result register.
// Depends on lph_pkg and lph_hash.
module lph_back import lph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              init_busy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [SLOT_W-1:0] slot_out,
    output logic [63:0]       key_out,
    output logic [PAY_W-1:0]  payload_out
);

    logic [63:0]      slot_keys [SLOTS];
    logic [PAY_W-1:0] slot_payloads [SLOTS];

    bstate_t          state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [63:0]      key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [IDX_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] gap_reg, gap_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             init_reg, init_next;
    logic [2:0]       rst_reg, rst_next;
    logic [IDX_W-1:0] rslot_reg, rslot_next;
    logic [63:0]      rkey_res_reg, rkey_res_next;
    logic [PAY_W-1:0] rpay_res_reg, rpay_res_next;
    logic [63:0]      mv_key_reg, mv_key_next;
    logic [PAY_W-1:0] mv_pay_reg, mv_pay_next;

    logic [63:0]      rkey_reg;
    logic [PAY_W-1:0] rpay_reg;

    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [IDX_W-1:0] slot_out_reg;
    logic [63:0]      key_out_reg;
    logic [PAY_W-1:0] pay_out_reg;
    logic             out_load;

    logic             we;
    logic [IDX_W-1:0] wa;
    logic [63:0]      wk;
    logic [PAY_W-1:0] wp;

    logic             hstart;
    logic             hdone;
    logic [IDX_W-1:0] hbase;
    logic             stays;

    lph_hash u_hash
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hstart),
        .key   (rkey_reg),
        .done  (hdone),
        .home  (hbase)
    );

    always_comb
    begin
        if (gap_reg <= s_reg)
        begin
            stays = (gap_reg < hbase) && (hbase <= s_reg);
        end
        else
        begin
            stays = (gap_reg < hbase) || (hbase <= s_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        s_next        = s_reg;
        gap_next      = gap_reg;
        n_next        = n_reg;
        init_next     = init_reg;
        rst_next      = rst_reg;
        rslot_next    = rslot_reg;
        rkey_res_next = rkey_res_reg;
        rpay_res_next = rpay_res_reg;
        mv_key_next   = mv_key_reg;
        mv_pay_next   = mv_pay_reg;
        q_pop         = 1'b0;
        we            = 1'b0;
        wa            = s_reg;
        wk            = '0;
        wp            = '0;
        hstart        = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            B_INIT:
            begin
                we = 1'b1;
                wa = IDX_W'(n_reg);
                if (n_reg == CNT_W'(SLOTS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? B_IDLE : B_EMIT;
                end
                n_next = n_reg + 1'b1;
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_item.cmd;
                    key_next      = q_item.key;
                    pay_next      = q_item.payload;
                    s_next        = q_item.slot;
                    n_next        = '0;
                    rst_next      = ST_OK;
                    rslot_next    = '0;
                    rkey_res_next = '0;
                    rpay_res_next = '0;
                    unique case (q_item.cmd)
                        CMD_CLEAR: state_next = B_INIT;
                        CMD_MISS:
                        begin
                            rst_next   = ST_MISS;
                            state_next = B_EMIT;
                        end
                        CMD_ZERO:
                        begin
                            rst_next   = ST_ZERO;
                            state_next = B_EMIT;
                        end
                        default: state_next = B_RD;
                    endcase
                end
            end
            B_RD:
            begin
                state_next = B_CMP;
            end
            B_CMP:
            begin
                state_next = B_EMIT;
                priority if (cmd_reg == CMD_READ)
                begin
                    rslot_next    = s_reg;
                    rkey_res_next = rkey_reg;
                    rpay_res_next = rpay_reg;
                end
                else if (cmd_reg == CMD_ERASE)
                begin
                    rslot_next = s_reg;
                    if (rkey_reg == '0)
                    begin
                        rst_next = ST_MISS;
                    end
                    else
                    begin
                        rkey_res_next = rkey_reg;
                        rpay_res_next = rpay_reg;
                        gap_next      = s_reg;
                        state_next    = B_EZERO;
                    end
                end
                else if (rkey_reg == '0)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        rst_next = ST_MISS;
                    end
                    else
                    begin
                        we            = 1'b1;
                        wk            = key_reg;
                        wp            = pay_reg;
                        rslot_next    = s_reg;
                        rkey_res_next = key_reg;
                        rpay_res_next = pay_reg;
                    end
                end
                else if (rkey_reg == key_reg)
                begin
                    rst_next      = (cmd_reg == CMD_LOOKUP) ? ST_OK : ST_DUP;
                    rslot_next    = s_reg;
                    rkey_res_next = rkey_reg;
                    rpay_res_next = rpay_reg;
                end
                else if (n_reg == CNT_W'(SLOTS - 1))
                begin
                    rst_next = (cmd_reg == CMD_LOOKUP) ? ST_MISS : ST_FULL;
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_EZERO:
            begin
                we         = 1'b1;
                wa         = gap_reg;
                s_next     = gap_reg + 1'b1;
                state_next = B_ERD;
            end
            B_ERD:
            begin
                state_next = B_ECMP;
            end
            B_ECMP:
            begin
                if (rkey_reg == '0)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    hstart      = 1'b1;
                    mv_key_next = rkey_reg;
                    mv_pay_next = rpay_reg;
                    state_next  = B_EHASH;
                end
            end
            B_EHASH:
            begin
                if (hdone)
                begin
                    if (stays)
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = B_ERD;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wa         = gap_reg;
                        wk         = mv_key_reg;
                        wp         = mv_pay_reg;
                        gap_next   = s_reg;
                        state_next = B_EZERO;
                    end
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            init_reg      <= 1'b1;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            n_reg     <= n_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        s_reg        <= s_next;
        gap_reg      <= gap_next;
        rst_reg      <= rst_next;
        rslot_reg    <= rslot_next;
        rkey_res_reg <= rkey_res_next;
        rpay_res_reg <= rpay_res_next;
        mv_key_reg   <= mv_key_next;
        mv_pay_reg   <= mv_pay_next;
        if (out_load)
        begin
            status_reg   <= rst_reg;
            slot_out_reg <= rslot_reg;
            key_out_reg  <= rkey_res_reg;
            pay_out_reg  <= rpay_res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_keys[wa]     <= wk;
            slot_payloads[wa] <= wp;
        end
        rkey_reg <= slot_keys[s_reg];
        rpay_reg <= slot_payloads[s_reg];
    end

    assign init_busy   = init_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_out    = SLOT_W'(slot_out_reg);
    assign key_out     = key_out_reg;
    assign payload_out = pay_out_reg;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the linear-probe hash table.
// Predicts every result with its own table model and checks each result item in order.
// Depends on lph_pkg and linear_probe_hash_table.
module testbench;
    import lph_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        op = OP_LOOKUP;
    logic [63:0]       key = '0;
    logic [SLOT_W-1:0] slot_index = '0;
    logic [PAY_W-1:0]  payload_in = '0;
    logic              out_valid;
    logic              out_stall = 1'b1;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_out;
    logic [63:0]       key_out;
    logic [PAY_W-1:0]  payload_out;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       key;
        logic [PAY_W-1:0]  payload;
    } table_reply_t;

    logic [63:0]      model_keys [SLOTS];
    logic [PAY_W-1:0] model_pays [SLOTS];
    table_reply_t     pending_replies [$];
    logic [63:0]      live_keys [$];
    int               failures = 0;
    int               cycle_count = 0;
    int               idle_pct = 32;
    bit               hold_off = 1'b0;

    always #4 clk = ~clk;

    linear_probe_hash_table i_dut (.*);

    function automatic int home_of(logic [63:0] k);
        logic [63:0] h;
        h = k * HASH_MULT;
        return int'(h >> (64 - IDX_W));
    endfunction

    function automatic void shift_back(int gap);
        int scan;
        int base;
        bit stays;
        bit moved;
        for (int r = 0; r < SLOTS; r++)
        begin
            model_keys[gap] = '0;
            model_pays[gap] = '0;
            scan = gap;
            moved = 1'b0;
            for (int n = 0; n < SLOTS; n++)
            begin
                scan = (scan + 1) % SLOTS;
                if (model_keys[scan] == '0)
                    return;
                base = home_of(model_keys[scan]);
                if (gap <= scan)
                    stays = (gap < base) && (base <= scan);
                else
                    stays = (gap < base) || (base <= scan);
                if (!stays)
                begin
                    moved = 1'b1;
                    break;
                end
            end
            if (!moved)
                return;
            model_keys[gap] = model_keys[scan];
            model_pays[gap] = model_pays[scan];
            gap = scan;
        end
    endfunction

    function automatic table_reply_t predict_table(logic [2:0] o, logic [63:0] k,
                                                   logic [SLOT_W-1:0] si, logic [PAY_W-1:0] p);
        table_reply_t r;
        int s;
        r = '{ST_MISS, '0, '0, '0};
        if (o == OP_LOOKUP || o == OP_INSERT)
        begin
            if (k == '0)
            begin
                if (o == OP_INSERT)
                    r.status = ST_ZERO;
                return r;
            end
            s = home_of(k);
            for (int n = 0; n < SLOTS; n++)
            begin
                if (model_keys[s] == '0)
                begin
                    if (o == OP_INSERT)
                    begin
                        model_keys[s] = k;
                        model_pays[s] = p;
                        r = '{ST_OK, s[SLOT_W-1:0], k, p};
                    end
                    return r;
                end
                if (model_keys[s] == k)
                    return '{(o == OP_LOOKUP) ? ST_OK : ST_DUP, s[SLOT_W-1:0], k, model_pays[s]};
                s = (s + 1) % SLOTS;
            end
            if (o == OP_INSERT)
                r.status = ST_FULL;
        end
        else if (o == OP_ERASE || o == OP_READ)
        begin
            if (int'(si) >= SLOTS)
                return r;
            r = '{ST_OK, si, model_keys[si], model_pays[si]};
            if (o == OP_ERASE)
            begin
                if (r.key == '0)
                    r.status = ST_MISS;
                else
                    shift_back(int'(si));
            end
        end
        else if (o == OP_CLEAR)
        begin
            foreach (model_keys[i])
            begin
                model_keys[i] = '0;
                model_pays[i] = '0;
            end
            r.status = ST_OK;
        end
        return r;
    endfunction

    task automatic send_item(logic [2:0] o, logic [63:0] k, logic [SLOT_W-1:0] si,
                             logic [PAY_W-1:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key <= k;
        slot_index <= si;
        payload_in <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_replies.push_back(predict_table(o, k, si, p));
        if (o == OP_INSERT && k != '0)
            live_keys.push_back(k);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_key();
        if (live_keys.size() != 0 && $urandom_range(1))
            return live_keys[$urandom_range(live_keys.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        table_reply_t want;
        table_reply_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, slot_out, key_out, payload_out};
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected item status=%0d slot=%0d key=%h payload=%h",
                         $time, status, slot_out, key_out, payload_out);
                failures++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got != want)
                begin
                    $display("%0t mismatch expected %0d/%0d/%h/%h actual %0d/%0d/%h/%h",
                             $time, want.status, want.slot, want.key, want.payload,
                             got.status, got.slot, got.key, got.payload);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 3000000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed;
        logic [63:0] k;
        logic [63:0] last_key;
        int          target;
        int          found;
        send_item(OP_LOOKUP, '0, '0, '0);
        send_item(OP_INSERT, '0, '0, '1);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, '0, 32'h1);
        send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_item(OP_LOOKUP, 64'h1, '0, '0);
        // Keys with the same home slot build one cluster.
        target = home_of(64'h1);
        found = 0;
        k = 64'h1;
        last_key = 64'h1;
        while (found < 4)
        begin
            if (home_of(k) == target)
            begin
                send_item(OP_INSERT, k, '0, 32'(found + 1));
                last_key = k;
                found++;
            end
            k++;
        end
        send_item(OP_ERASE, '0, 10'(target), '0);
        send_item(OP_LOOKUP, last_key, '0, '0);
        send_item(OP_ERASE, '0, 10'h3FF, '0);
        send_item(OP_ERASE, '0, 10'h3FF, '0);
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, '0, 10'h3FF, '0);
        send_item(3'd5, 64'h5, '0, '0);
        send_item(3'd6, '0, '0, '0);
        send_item(3'd7, '1, '1, '1);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_READ, '0, 10'(target), '0);
        drain();
    endtask

    task automatic test_full_table;
        for (int i = 0; i < SLOTS; i++)
            send_item(OP_INSERT, {$urandom | 32'h1, $urandom}, '0, $urandom);
        send_item(OP_INSERT, 64'hDEAD_BEEF_0000_0001, '0, '0);
        send_item(OP_LOOKUP, 64'hDEAD_BEEF_0000_0001, '0, '0);
        send_item(OP_CLEAR, '0, '0, '0);
        live_keys.delete();
        drain();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_item(OP_INSERT, {$urandom, $urandom}, '0, $urandom);
        join
        drain();
    endtask

    task automatic test_random;
        int pick;
        for (int i = 0; i < 150; i++)
        begin
            idle_pct = (i >= 50 && i < 100) ? 0 : 32;
            pick = $urandom_range(99);
            if (pick < 35)
                send_item(OP_INSERT, pick_key(), 10'($urandom), $urandom);
            else if (pick < 60)
                send_item(OP_LOOKUP, pick_key(), 10'($urandom), $urandom);
            else if (pick < 80)
                send_item(OP_ERASE, {$urandom, $urandom}, 10'($urandom), $urandom);
            else if (pick < 95)
                send_item(OP_READ, {$urandom, $urandom}, 10'($urandom), $urandom);
            else if (pick < 97)
                send_item(3'($urandom_range(5, 7)), {$urandom, $urandom}, 10'($urandom), $urandom);
            else
            begin
                send_item(OP_CLEAR, {$urandom, $urandom}, 10'($urandom), $urandom);
                live_keys.delete();
            end
        end
        idle_pct = 32;
        drain();
    endtask

    initial
    begin
        foreach (model_keys[i])
        begin
            model_keys[i] = '0;
            model_pays[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_full_table();
        test_random();
        repeat (2200) @(posedge clk);
        if (failures == 0 && pending_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
